/* rtl/core/nmpr_pkg.sv */
package nmpr_pkg;

  // Pixel channel width and derived arithmetic widths
  localparam int PIX_W   = 8;
  localparam int PIX_MAX = (2 ** PIX_W) - 1;
  localparam int LGT_W   = 16;               // Q1.14 light component
  localparam int CFG_W   = LGT_W;            // widest register
  localparam int IDX_W   = 3;
  localparam int NRM_W   = PIX_W + 2;        // signed decoded normal component
  localparam int PRD_W   = NRM_W + LGT_W;    // one signed product
  localparam int DOT_W   = PRD_W + 2;        // signed sum of three products
  localparam int MAG_W   = DOT_W - 1;        // magnitude of a positive dot product
  localparam int REM_W   = PIX_W + MAG_W;    // channel times numerator
  localparam int Q_W     = PIX_W + 1;        // quotient bits, top one is saturation

  localparam logic [PIX_W-1:0] SHADOW_BLUE = PIX_W'(2 ** (PIX_W - 2));

  // Register indexes
  localparam logic [IDX_W-1:0] REG_VIEW_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_OLD_LIGHT_X = 3'd1;
  localparam logic [IDX_W-1:0] REG_OLD_LIGHT_Y = 3'd2;
  localparam logic [IDX_W-1:0] REG_OLD_LIGHT_Z = 3'd3;
  localparam logic [IDX_W-1:0] REG_NEW_LIGHT_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_NEW_LIGHT_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_NEW_LIGHT_Z = 3'd6;

  // View modes; the unused code behaves as relight
  localparam logic [1:0] MODE_NEEDLE  = 2'd0;
  localparam logic [1:0] MODE_IMAGE   = 2'd1;
  localparam logic [1:0] MODE_RELIGHT = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] needle_red;
    logic [PIX_W-1:0] needle_green;
    logic [PIX_W-1:0] needle_blue;
    logic [PIX_W-1:0] image_red;
    logic [PIX_W-1:0] image_green;
    logic [PIX_W-1:0] image_blue;
  } in_pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
  } out_pix_t;

  typedef struct packed {
    logic [LGT_W-1:0] x;
    logic [LGT_W-1:0] y;
    logic [LGT_W-1:0] z;
  } light_t;

  // Side information carried down the pipe with each pixel
  typedef struct packed {
    logic                  pass;    // copy pix straight out
    logic                  shadow;  // old shading not positive
    logic [2:0][PIX_W-1:0] pix;     // [0] red, [1] green, [2] blue
  } side_t;

  typedef logic [2:0][REM_W-1:0] rem3_t;
  typedef logic [2:0][Q_W-1:0]   q3_t;

endpackage

/* rtl/core/nmpr_dot.sv */
module nmpr_dot (
  input  logic                                clk_i,
  input  logic                                en1_i,
  input  logic                                en2_i,
  input  nmpr_pkg::in_pix_t                   pix_i,
  input  logic [1:0]                          mode_i,
  input  nmpr_pkg::light_t                    old_light_i,
  input  nmpr_pkg::light_t                    new_light_i,
  output logic signed [nmpr_pkg::DOT_W-1:0]   dot_old_o,
  output logic signed [nmpr_pkg::DOT_W-1:0]   dot_new_o,
  output nmpr_pkg::side_t                     side_o
);

  logic signed [nmpr_pkg::NRM_W-1:0] nx, ny, nz;
  logic signed [nmpr_pkg::PRD_W-1:0] po_d [3];
  logic signed [nmpr_pkg::PRD_W-1:0] pn_d [3];
  logic signed [nmpr_pkg::PRD_W-1:0] po_q [3];
  logic signed [nmpr_pkg::PRD_W-1:0] pn_q [3];
  nmpr_pkg::side_t                   side_d, side1_q;
  logic signed [nmpr_pkg::DOT_W-1:0] dot_old_d, dot_new_d;

  // Decode normal and form the six products
  always_comb begin
    nx = $signed({1'b0, pix_i.needle_red, 1'b0})
       - $signed(nmpr_pkg::NRM_W'(nmpr_pkg::PIX_MAX));
    ny = $signed({1'b0, pix_i.needle_green, 1'b0})
       - $signed(nmpr_pkg::NRM_W'(nmpr_pkg::PIX_MAX));
    nz = $signed({2'b00, pix_i.needle_blue});
    po_d[0] = nx * $signed(old_light_i.x);
    po_d[1] = ny * $signed(old_light_i.y);
    po_d[2] = nz * $signed(old_light_i.z);
    pn_d[0] = nx * $signed(new_light_i.x);
    pn_d[1] = ny * $signed(new_light_i.y);
    pn_d[2] = nz * $signed(new_light_i.z);
  end

  // Pass modes pick their pixel here; relight carries the image pixel
  always_comb begin
    side_d.pass   = (mode_i == nmpr_pkg::MODE_NEEDLE) || (mode_i == nmpr_pkg::MODE_IMAGE);
    side_d.shadow = 1'b0;
    if (mode_i == nmpr_pkg::MODE_NEEDLE) begin
      side_d.pix = {pix_i.needle_blue, pix_i.needle_green, pix_i.needle_red};
    end else begin
      side_d.pix = {pix_i.image_blue, pix_i.image_green, pix_i.image_red};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      po_q    <= po_d;
      pn_q    <= pn_d;
      side1_q <= side_d;
    end
  end

  // Sum the products
  always_comb begin
    dot_old_d = nmpr_pkg::DOT_W'(po_q[0]) + nmpr_pkg::DOT_W'(po_q[1])
              + nmpr_pkg::DOT_W'(po_q[2]);
    dot_new_d = nmpr_pkg::DOT_W'(pn_q[0]) + nmpr_pkg::DOT_W'(pn_q[1])
              + nmpr_pkg::DOT_W'(pn_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      dot_old_o <= dot_old_d;
      dot_new_o <= dot_new_d;
      side_o    <= side1_q;
    end
  end

endmodule

/* rtl/core/nmpr_scale.sv */
module nmpr_scale (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [nmpr_pkg::DOT_W-1:0]   dot_old_i,
  input  logic signed [nmpr_pkg::DOT_W-1:0]   dot_new_i,
  input  nmpr_pkg::side_t                     side_i,
  output nmpr_pkg::rem3_t                     rem_o,
  output logic [nmpr_pkg::MAG_W-1:0]          den_o,
  output nmpr_pkg::side_t                     side_o
);

  logic [nmpr_pkg::MAG_W-1:0] num;
  nmpr_pkg::rem3_t            rem_d;
  nmpr_pkg::side_t            side_d;

  // Negative new shading gives a zero numerator, hence a zero channel
  always_comb begin
    num = (dot_new_i > 0) ? dot_new_i[nmpr_pkg::MAG_W-1:0] : '0;
    for (int l = 0; l < 3; l++) begin
      rem_d[l] = nmpr_pkg::REM_W'(side_i.pix[l]) * nmpr_pkg::REM_W'(num);
    end
    side_d        = side_i;
    side_d.shadow = !(dot_old_i > 0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      den_o  <= dot_old_i[nmpr_pkg::MAG_W-1:0];
      side_o <= side_d;
    end
  end

endmodule

/* rtl/core/nmpr_div_step.sv */
module nmpr_div_step #(
  parameter int SHIFT = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  nmpr_pkg::rem3_t             rem_i,
  input  nmpr_pkg::q3_t               q_i,
  input  logic [nmpr_pkg::MAG_W-1:0]  den_i,
  input  nmpr_pkg::side_t             side_i,
  output nmpr_pkg::rem3_t             rem_o,
  output nmpr_pkg::q3_t               q_o,
  output logic [nmpr_pkg::MAG_W-1:0]  den_o,
  output nmpr_pkg::side_t             side_o
);

  logic [nmpr_pkg::REM_W-1:0] dsh;
  logic [2:0]                 qbit;
  nmpr_pkg::rem3_t            rem_d;
  nmpr_pkg::q3_t              q_d;

  // One restoring step per lane: compare with the shifted divisor
  always_comb begin
    dsh = nmpr_pkg::REM_W'(den_i) << SHIFT;
    for (int l = 0; l < 3; l++) begin
      qbit[l]  = (rem_i[l] >= dsh);
      rem_d[l] = qbit[l] ? (rem_i[l] - dsh) : rem_i[l];
      q_d[l]   = {q_i[l][nmpr_pkg::Q_W-2:0], qbit[l]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      q_o    <= q_d;
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

/* rtl/core/normal_map_pixel_relighter_core.sv */
// Normal-map pixel relighter.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one pixel per
// transfer: a needle-map colour and an image colour. Output channel
// (out_valid_o / out_stall_i / out_data_o) returns one colour per pixel,
// in order. Registers must be written by the user through cfg_we_i /
// cfg_idx_i / cfg_data_i only while no pixel is in flight; the block
// itself does not enforce this. Indexes beyond the last register are
// ignored. Throughput: one pixel per cycle while the receiver does not
// stall. The pipe holds two dot-product stages, one scaling multiply
// stage, one restoring division step per quotient bit (saturation bit
// included) and the output register.
// Each stage holds a valid bit and loads whenever it or a stage below is
// free, so bubbles are squeezed out: when the receiver stalls, the pipe keeps
// taking pixels until it is full, then in_stall_o rises. Nothing is dropped
// or repeated. Reset empties the pipe and returns the registers to relight
// mode with both lights along +z.
module normal_map_pixel_relighter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nmpr_pkg::in_pix_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nmpr_pkg::out_pix_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [nmpr_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [nmpr_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int DIV_ST = 3;
  localparam int NUM_ST = DIV_ST + nmpr_pkg::Q_W + 1;

  // Configuration registers
  logic [1:0]        mode_q;
  nmpr_pkg::light_t  old_light_q, new_light_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= nmpr_pkg::MODE_RELIGHT;
      old_light_q <= '{x: '0, y: '0, z: nmpr_pkg::LGT_W'(16384)};
      new_light_q <= '{x: '0, y: '0, z: nmpr_pkg::LGT_W'(16384)};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nmpr_pkg::REG_VIEW_MODE:   mode_q        <= cfg_data_i[1:0];
        nmpr_pkg::REG_OLD_LIGHT_X: old_light_q.x <= cfg_data_i;
        nmpr_pkg::REG_OLD_LIGHT_Y: old_light_q.y <= cfg_data_i;
        nmpr_pkg::REG_OLD_LIGHT_Z: old_light_q.z <= cfg_data_i;
        nmpr_pkg::REG_NEW_LIGHT_X: new_light_q.x <= cfg_data_i;
        nmpr_pkg::REG_NEW_LIGHT_Y: new_light_q.y <= cfg_data_i;
        nmpr_pkg::REG_NEW_LIGHT_Z: new_light_q.z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage load enables
  logic [NUM_ST-1:0] vld_q, vld_d, rdy;

  assign rdy[NUM_ST-1] = !vld_q[NUM_ST-1] || !out_stall_i;
  for (genvar k = 0; k < NUM_ST - 1; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  always_comb begin
    for (int k = 0; k < NUM_ST; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NUM_ST-1];

  // Dot products
  logic signed [nmpr_pkg::DOT_W-1:0] dot_old, dot_new;
  nmpr_pkg::side_t                   side_dot;

  nmpr_dot u_dot (
    .clk_i       (clk_i),
    .en1_i       (rdy[0]),
    .en2_i       (rdy[1]),
    .pix_i       (in_data_i),
    .mode_i      (mode_q),
    .old_light_i (old_light_q),
    .new_light_i (new_light_q),
    .dot_old_o   (dot_old),
    .dot_new_o   (dot_new),
    .side_o      (side_dot)
  );

  // Division chain, index 0 fed by the scaling stage
  nmpr_pkg::rem3_t            rem_c  [nmpr_pkg::Q_W+1];
  nmpr_pkg::q3_t              q_c    [nmpr_pkg::Q_W+1];
  logic [nmpr_pkg::MAG_W-1:0] den_c  [nmpr_pkg::Q_W+1];
  nmpr_pkg::side_t            side_c [nmpr_pkg::Q_W+1];

  nmpr_scale u_scale (
    .clk_i     (clk_i),
    .en_i      (rdy[2]),
    .dot_old_i (dot_old),
    .dot_new_i (dot_new),
    .side_i    (side_dot),
    .rem_o     (rem_c[0]),
    .den_o     (den_c[0]),
    .side_o    (side_c[0])
  );

  assign q_c[0] = '0;

  for (genvar j = 0; j < nmpr_pkg::Q_W; j++) begin : g_div
    nmpr_div_step #(
      .SHIFT (nmpr_pkg::PIX_W - j)
    ) u_step (
      .clk_i  (clk_i),
      .en_i   (rdy[DIV_ST+j]),
      .rem_i  (rem_c[j]),
      .q_i    (q_c[j]),
      .den_i  (den_c[j]),
      .side_i (side_c[j]),
      .rem_o  (rem_c[j+1]),
      .q_o    (q_c[j+1]),
      .den_o  (den_c[j+1]),
      .side_o (side_c[j+1])
    );
  end

  // Result selection and saturation
  nmpr_pkg::side_t            side_f;
  nmpr_pkg::q3_t              q_f;
  logic [2:0][nmpr_pkg::PIX_W-1:0] chan;
  nmpr_pkg::out_pix_t         out_d, out_q;

  always_comb begin
    side_f = side_c[nmpr_pkg::Q_W];
    q_f    = q_c[nmpr_pkg::Q_W];
    for (int l = 0; l < 3; l++) begin
      if (side_f.pass) begin
        chan[l] = side_f.pix[l];
      end else if (q_f[l][nmpr_pkg::Q_W-1]) begin
        chan[l] = nmpr_pkg::PIX_W'(nmpr_pkg::PIX_MAX);
      end else begin
        chan[l] = q_f[l][nmpr_pkg::PIX_W-1:0];
      end
    end
    if (!side_f.pass && side_f.shadow) begin
      out_d = '{out_red: '0, out_green: '0, out_blue: nmpr_pkg::SHADOW_BLUE};
    end else begin
      out_d = '{out_red: chan[0], out_green: chan[1], out_blue: chan[2]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NUM_ST-1]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

/* rtl/core/nmpr_checker.sv */
module nmpr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input nmpr_pkg::out_pix_t out_data_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // The pipe only back-pressures when the receiver does
  a_no_spurious_stall: assert property (@(posedge clk_i)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with receiver free");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("pipe not empty in reset");

  // Nothing comes out of an empty pipe right after reset
  a_first_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind normal_map_pixel_relighter_core nmpr_checker u_nmpr_checker (.*);

/* dv/normal_map_pixel_relighter_core_test.sv */
module normal_map_pixel_relighter_core_test;

  localparam int CLK_HALF = 6;
  localparam int PIPE_LATENCY = 4 + nmpr_pkg::PIX_W + 1;
  localparam int DRAIN_LIMIT = 4000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_PIXELS = 136;
  localparam int PRINT_LIMIT = 40;

  // The index past the last register, and the mode code left unused
  localparam logic [nmpr_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [nmpr_pkg::PIX_W-1:0] SHADOW_BLUE = nmpr_pkg::SHADOW_BLUE;

  // One complete register setting
  typedef struct packed {
    logic [1:0] mode;
    shortint    old_x;
    shortint    old_y;
    shortint    old_z;
    shortint    new_x;
    shortint    new_y;
    shortint    new_z;
  } relight_cfg_t;

  typedef struct packed {
    logic [2:0]         preset;
    nmpr_pkg::in_pix_t  pix;
    logic               typed;   // want is read straight off the row
    nmpr_pkg::out_pix_t want;
  } directed_row_t;

  // Reset values first, then pass modes, spare mode, opposed lights,
  // over-bright lights, register extremes and a light that zeroes the old shading
  localparam relight_cfg_t PRESETS [8] = '{
    '{nmpr_pkg::MODE_RELIGHT, 0, 0, 16384, 0, 0, 16384},
    '{nmpr_pkg::MODE_NEEDLE, 0, 0, 16384, 0, 0, 16384},
    '{nmpr_pkg::MODE_IMAGE, 0, 0, 16384, 0, 0, 16384},
    '{MODE_SPARE, 0, 0, 16384, 0, 0, 16384},
    '{nmpr_pkg::MODE_RELIGHT, 16384, 0, 0, -16384, 0, 0},
    '{nmpr_pkg::MODE_RELIGHT, 0, 0, 16384, 16384, 0, 0},
    '{nmpr_pkg::MODE_RELIGHT, -32768, 32767, -32768, 32767, -32768, 32767},
    '{nmpr_pkg::MODE_RELIGHT, 16384, -16384, 0, 0, 0, 16384}
  };

  localparam directed_row_t DIRECTED_ROWS [22] = '{
    // reset setting: zero needle colour (normal with no z part) in shadow, then image copied through
    '{3'd0, '{8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, SHADOW_BLUE}},
    '{3'd0, '{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h80}, 1'b1, '{8'hff, 8'h00, 8'h80}},
    '{3'd0, '{8'h00, 8'hff, 8'h01, 8'h01, 8'hfe, 8'h7f}, 1'b1, '{8'h01, 8'hfe, 8'h7f}},
    // pass modes
    '{3'd1, '{8'ha5, 8'h5a, 8'hff, 8'h00, 8'h11, 8'h22}, 1'b1, '{8'ha5, 8'h5a, 8'hff}},
    '{3'd1, '{8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{3'd2, '{8'ha5, 8'h5a, 8'hff, 8'h00, 8'h11, 8'h22}, 1'b1, '{8'h00, 8'h11, 8'h22}},
    '{3'd2, '{8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'hff, 8'hff, 8'hff}},
    // spare mode relights
    '{3'd3, '{8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56}, 1'b1, '{8'h00, 8'h00, SHADOW_BLUE}},
    '{3'd3, '{8'h80, 8'h80, 8'hc8, 8'h12, 8'h34, 8'h56}, 1'b1, '{8'h12, 8'h34, 8'h56}},
    // negative new shading, and old shading below zero
    '{3'd4, '{8'hff, 8'h80, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    '{3'd4, '{8'h00, 8'h80, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, SHADOW_BLUE}},
    // over-bright saturation
    '{3'd5, '{8'hff, 8'h80, 8'h01, 8'h01, 8'h00, 8'hff}, 1'b1, '{8'hff, 8'h00, 8'hff}},
    '{3'd5, '{8'hc0, 8'h80, 8'hff, 8'h80, 8'h40, 8'h20}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{3'd5, '{8'h7f, 8'h80, 8'h02, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, 8'h00}},
    // register extremes
    '{3'd6, '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{3'd6, '{8'h00, 8'h00, 8'hff, 8'hff, 8'h80, 8'h01}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{3'd6, '{8'hff, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{3'd6, '{8'h00, 8'hff, 8'h80, 8'h01, 8'h02, 8'h03}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    // old shading exactly zero or just above it, then earlier settings again
    '{3'd7, '{8'h80, 8'h80, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, SHADOW_BLUE}},
    '{3'd7, '{8'h81, 8'h80, 8'h10, 8'hff, 8'h10, 8'h00}, 1'b0, '{8'h00, 8'h00, 8'h00}},
    '{3'd0, '{8'h5a, 8'ha5, 8'h80, 8'h7e, 8'h81, 8'hc3}, 1'b1, '{8'h7e, 8'h81, 8'hc3}},
    '{3'd3, '{8'hff, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, SHADOW_BLUE}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  nmpr_pkg::in_pix_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  nmpr_pkg::out_pix_t out_data_o;
  logic cfg_we_i;
  logic [nmpr_pkg::IDX_W-1:0] cfg_idx_i;
  logic [nmpr_pkg::CFG_W-1:0] cfg_data_i;

  relight_cfg_t lights_now;
  nmpr_pkg::out_pix_t pending_colours [$];
  nmpr_pkg::out_pix_t oldest;
  logic [2:0][nmpr_pkg::PIX_W-1:0] got_chan;
  logic [2:0][nmpr_pkg::PIX_W-1:0] want_chan;
  string chan_name [3] = '{"blue", "green", "red"};
  int mismatches = 0;
  int colours_seen = 0;
  int tx_idle_max = 3;
  int rx_idle_max = 3;
  int rx_hold_request = 0;
  int cur_preset;

  normal_map_pixel_relighter_core dut (.*);

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // One colour channel scaled by new/old shading, floored and clamped
  function automatic logic [nmpr_pkg::PIX_W-1:0] shade(input longint c, input longint num,
                                                      input longint den);
    longint q;
    if (num <= 0) return '0;
    q = (c * num) / den;
    if (q > nmpr_pkg::PIX_MAX) q = nmpr_pkg::PIX_MAX;
    return q[nmpr_pkg::PIX_W-1:0];
  endfunction

  function automatic nmpr_pkg::out_pix_t relit_colour(input nmpr_pkg::in_pix_t p);
    longint nx, ny, nz, dot_old, dot_new;
    nmpr_pkg::out_pix_t r;
    if (lights_now.mode == nmpr_pkg::MODE_NEEDLE) begin
      return '{p.needle_red, p.needle_green, p.needle_blue};
    end
    if (lights_now.mode == nmpr_pkg::MODE_IMAGE) begin
      return '{p.image_red, p.image_green, p.image_blue};
    end
    nx = 2 * longint'(p.needle_red) - nmpr_pkg::PIX_MAX;
    ny = 2 * longint'(p.needle_green) - nmpr_pkg::PIX_MAX;
    nz = longint'(p.needle_blue);
    dot_old = nx * lights_now.old_x + ny * lights_now.old_y + nz * lights_now.old_z;
    dot_new = nx * lights_now.new_x + ny * lights_now.new_y + nz * lights_now.new_z;
    if (dot_old > 0) begin
      r.out_red = shade(longint'(p.image_red), dot_new, dot_old);
      r.out_green = shade(longint'(p.image_green), dot_new, dot_old);
      r.out_blue = shade(longint'(p.image_blue), dot_new, dot_old);
    end else begin
      r = '{'0, '0, SHADOW_BLUE};
    end
    return r;
  endfunction

  // Offer one pixel after a random gap and hold it until the transfer
  task automatic send_pixel(input nmpr_pkg::in_pix_t p, input nmpr_pkg::out_pix_t want);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_colours.push_back(want);
  endtask

  // Stop offering and wait for every outstanding colour
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_colours.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_colours.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_colours.size()));
      pending_colours.delete();
    end
  endtask

  task automatic write_reg(input logic [nmpr_pkg::IDX_W-1:0] idx,
                           input logic [nmpr_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_setting(input relight_cfg_t s);
    logic [nmpr_pkg::CFG_W-3:0] junk;
    junk = (nmpr_pkg::CFG_W-2)'($urandom);
    drain_results();
    write_reg(nmpr_pkg::REG_VIEW_MODE, {junk, s.mode});
    write_reg(nmpr_pkg::REG_OLD_LIGHT_X, s.old_x);
    write_reg(nmpr_pkg::REG_OLD_LIGHT_Y, s.old_y);
    write_reg(nmpr_pkg::REG_OLD_LIGHT_Z, s.old_z);
    write_reg(nmpr_pkg::REG_NEW_LIGHT_X, s.new_x);
    write_reg(nmpr_pkg::REG_NEW_LIGHT_Y, s.new_y);
    write_reg(nmpr_pkg::REG_NEW_LIGHT_Z, s.new_z);
    // must leave every register alone
    write_reg(REG_UNUSED, nmpr_pkg::CFG_W'($urandom));
    lights_now = s;
  endtask

  function automatic logic [nmpr_pkg::PIX_W-1:0] random_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 8'h80;
      3: return 8'h7f;
      default: return nmpr_pkg::PIX_W'($urandom);
    endcase
  endfunction

  function automatic nmpr_pkg::in_pix_t random_pixel();
    nmpr_pkg::in_pix_t p;
    p.needle_red = random_channel();
    p.needle_green = random_channel();
    p.needle_blue = random_channel();
    p.image_red = random_channel();
    p.image_green = random_channel();
    p.image_blue = random_channel();
    return p;
  endfunction

  function automatic shortint random_component();
    case ($urandom_range(0, 5))
      0: return shortint'(16384);
      1: return shortint'(-16384);
      2: return shortint'(0);
      3: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      4: return shortint'(int'($urandom_range(0, 4000)) - 2000);
      default: return shortint'($urandom);
    endcase
  endfunction

  // Mostly relight; half the settings have a near-unit old light facing +z
  function automatic relight_cfg_t random_setting();
    relight_cfg_t s;
    case ($urandom_range(0, 9))
      0: s.mode = nmpr_pkg::MODE_NEEDLE;
      1: s.mode = nmpr_pkg::MODE_IMAGE;
      2: s.mode = MODE_SPARE;
      default: s.mode = nmpr_pkg::MODE_RELIGHT;
    endcase
    if ($urandom_range(0, 1)) begin
      s.old_x = shortint'(int'($urandom_range(0, 16000)) - 8000);
      s.old_y = shortint'(int'($urandom_range(0, 16000)) - 8000);
      s.old_z = shortint'($urandom_range(12000, 16384));
      s.new_x = shortint'(int'($urandom_range(0, 32768)) - 16384);
      s.new_y = shortint'(int'($urandom_range(0, 32768)) - 16384);
      s.new_z = shortint'(int'($urandom_range(0, 32768)) - 16384);
    end else begin
      s.old_x = random_component();
      s.old_y = random_component();
      s.old_z = random_component();
      s.new_x = random_component();
      s.new_y = random_component();
      s.new_z = random_component();
    end
    return s;
  endfunction

  // Receiver: random stall before each transfer, or a long hold when asked
  initial begin
    int stall_left;
    out_stall_i = 1'b0;
    forever begin
      if (rx_hold_request > 0) begin
        stall_left = rx_hold_request;
        rx_hold_request = 0;
      end else begin
        stall_left = $urandom_range(0, rx_idle_max);
      end
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_stall_i = 1'b1;
        repeat (stall_left) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare each transferred colour with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_colours.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", colours_seen));
      end else begin
        oldest = pending_colours.pop_front();
        got_chan = out_data_o;
        want_chan = oldest;
        for (int ch = 0; ch < 3; ch++) begin
          if (got_chan[ch] !== want_chan[ch])
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d", colours_seen,
                                      chan_name[ch], got_chan[ch], want_chan[ch]));
        end
      end
      colours_seen++;
    end
  end

  initial begin
    #(2 * CLK_HALF * 300000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    // clean falling edge well before the first rising clock edge
    rst_ni = 1'b1;
    lights_now = PRESETS[0];
    cur_preset = 0;
    #1;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows; the first ones run on the reset values
    foreach (DIRECTED_ROWS[i]) begin
      if (int'(DIRECTED_ROWS[i].preset) != cur_preset) begin
        cur_preset = DIRECTED_ROWS[i].preset;
        apply_setting(PRESETS[cur_preset]);
      end
      send_pixel(DIRECTED_ROWS[i].pix, DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].want
                                                            : relit_colour(DIRECTED_ROWS[i].pix));
    end

    // Random phases, each under a fresh setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_setting(random_setting());
      tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      if (phase == 1) begin
        // receiver holds off while pixels keep coming, so the pipe backs up
        tx_idle_max = 0;
        rx_hold_request = 120;
      end
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        if (phase == 4 && k == PHASE_PIXELS / 2) drain_results();
        begin
          nmpr_pkg::in_pix_t p;
          p = random_pixel();
          send_pixel(p, relit_colour(p));
        end
      end
    end

    drain_results();
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* normal_map_pixel_relighter_core.f */
rtl/core/nmpr_pkg.sv
rtl/core/nmpr_dot.sv
rtl/core/nmpr_scale.sv
rtl/core/nmpr_div_step.sv
rtl/core/normal_map_pixel_relighter_core.sv
rtl/core/nmpr_checker.sv
dv/normal_map_pixel_relighter_core_test.sv
